### rtl/core/pmf_pkg.sv
// ----------------------------------------------------------------------------
// pmf_pkg
// shared types, constants and helpers of the position majority fuser
// ----------------------------------------------------------------------------
package pmf_pkg;

	localparam int MAX_REPORTS = 16;
	localparam int IDX_W       = $clog2(MAX_REPORTS);
	localparam int CNT_W       = $clog2(MAX_REPORTS + 1);
	localparam int POS_W       = 16;
	localparam int SUM_W       = POS_W + IDX_W;
	localparam int BITCNT_W    = $clog2(SUM_W);
	localparam int CFG_IDX_W   = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_RADIUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_RADIUS = 1'b1;

	// status and kind bit positions
	localparam int ST_VISIBLE = 2;
	localparam int KD_WORLD   = 0;
	localparam int KD_CART    = 1;
	localparam int KD_POLAR   = 2;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       kind;
		logic [POS_W-1:0] wx;
		logic [POS_W-1:0] wy;
		logic [POS_W-1:0] wz;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	typedef enum logic [1:0] {
		SRC_OWN_NEAR = 2'd0,
		SRC_MAJORITY = 2'd1,
		SRC_OWN_COPY = 2'd2,
		SRC_NONE     = 2'd3
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OWN_MUL,
		ST_START,
		ST_GR2_MUL,
		ST_ANC_RD,
		ST_ANC_CHK,
		ST_MEM_RD,
		ST_MEM_MUL,
		ST_ANC_END,
		ST_PICK,
		ST_AVG_RD,
		ST_AVG_ACC,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_DONE,
		ST_RESULT
	} st_t;

	function automatic logic usable(entry_t e);
		logic ok;
		ok = (e.status == 3'b111) && e.kind[KD_WORLD];
		return ok;
	endfunction

	// magnitude of a 17 bit signed value, always fits 16 bits here
	function automatic logic [POS_W-1:0] mag17(logic [POS_W:0] v);
		logic [POS_W:0] n;
		n = v[POS_W] ? (~v + 1'b1) : v;
		return n[POS_W-1:0];
	endfunction

endpackage

### rtl/core/pmf_ram.sv
// ----------------------------------------------------------------------------
// pmf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/position_majority_fuser_core.sv
// ----------------------------------------------------------------------------
// position_majority_fuser_core
// collects object position reports and fuses them into one world position
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | content
//  ---------+-----+----------------------------------+---------------------------
//  s_       | in  | s_tvalid s_tready s_tdata s_tuser | one report, tlast ends set
//           |     | s_tlast                          |
//  m_       | out | m_tvalid m_tready m_tdata m_tuser | one fused result per set
//  cfg_     | in  | cfg_we cfg_index cfg_data        | radius registers
//
//  a plain report without the last mark leaves the block in idle; an own
//  report that is stored first runs its nearness check, the last report then
//  runs the grouping: all pairs of stored reports go through one shared
//  16x16 squarer; a majority adds a sum over the group and a restoring
//  division per axis; the input is only ready in idle; a finished result
//  waits in the output register and the next set loads meanwhile
//  reset clears the set, the radii go to 500 and 1000 mm
// ----------------------------------------------------------------------------
module position_majority_fuser_core
	import pmf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// report_status, world_x, world_y, world_z, rel_x, rel_y, rel_z, polar_range
	input  logic [119:0]         s_tdata,
	// is_own, kind_bits
	input  logic [3:0]           s_tuser,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// fused_x, fused_y, fused_z, world_present, seen, group_members
	output logic [55:0]          m_tdata,
	// result_source
	output logic [1:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	st_t state_q, state_d;

	// control registers
	logic [CNT_W-1:0] count_q;
	logic             own_valid_q;
	logic             own_near_q;
	logic             m_tvalid_q;
	logic [15:0]      self_radius_q;
	logic [15:0]      group_radius_q;

	// working registers
	logic [2:0]             ph_q;
	entry_t                 own_q;
	entry_t                 anc_q;
	logic [POS_W-1:0]       rel_x_q, rel_y_q, rel_z_q, polar_q;
	logic                   last_q;
	logic [2*POS_W-1:0]     prod_q;
	logic [2*POS_W+1:0]     acc_q;
	logic [2*POS_W-1:0]     gr2_q;
	logic [CNT_W-1:0]       i_q, j_q;
	logic [MAX_REPORTS-1:0] mask_q, best_q;
	logic [CNT_W-1:0]       size_q, best_size_q;
	logic                   unamb_q;
	logic [SUM_W-1:0]       sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]       avg_cnt_q;
	logic [1:0]             axis_q;
	logic [BITCNT_W-1:0]    bit_q;
	logic [SUM_W-1:0]       dvd_q;
	logic [CNT_W-1:0]       rem_q;
	logic                   neg_q;
	logic [POS_W-1:0]       qx_q, qy_q, qz_q;
	src_t                   src_q;
	logic [55:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	// combinational
	logic                 acc_in;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_raddr;
	entry_t               ram_wdata;
	logic [ENT_W-1:0]     ram_rdata;
	entry_t               rd_e;
	logic [POS_W-1:0]     mul_op;
	logic [2*POS_W+1:0]   dist2;
	logic                 in_group;
	logic                 out_free;
	logic [CNT_W:0]       rem_sh;
	logic [SUM_W-1:0]     sum_sel;
	logic [SUM_W-1:0]     q_fix;
	logic                 is_own_in;
	logic                 majority;

	assign acc_in    = s_tvalid && s_tready;
	assign is_own_in = s_tuser[0];
	assign out_free  = !m_tvalid_q || m_tready;
	assign rd_e      = entry_t'(ram_rdata);
	assign majority  = (best_size_q != '0) && unamb_q;

	assign ram_wdata.status = s_tdata[2:0];
	assign ram_wdata.kind   = s_tuser[3:1];
	assign ram_wdata.wx     = s_tdata[18:3];
	assign ram_wdata.wy     = s_tdata[34:19];
	assign ram_wdata.wz     = s_tdata[50:35];

	pmf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_REPORTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// squared distance of the current candidate, last axis still in prod_q
	assign dist2    = acc_q + {2'b00, prod_q};
	assign in_group = rd_e.kind[KD_WORLD] && (dist2 <= {2'b00, gr2_q});

	// one restoring divider step
	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};

	always_comb begin
		unique case (axis_q)
			2'd0:    sum_sel = sum_x_q;
			2'd1:    sum_sel = sum_y_q;
			default: sum_sel = sum_z_q;
		endcase
	end

	assign q_fix = neg_q ? (~dvd_q + 1'b1) : dvd_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					if ((count_q < CNT_W'(MAX_REPORTS)) && is_own_in) state_d = ST_OWN_MUL;
					else if (s_tlast) state_d = ST_START;
				end
			end
			ST_OWN_MUL:  if (ph_q == 3'd4) state_d = last_q ? ST_START : ST_IDLE;
			ST_START:    state_d = (own_valid_q && own_near_q) ? ST_RESULT : ST_GR2_MUL;
			ST_GR2_MUL:  if (ph_q == 3'd1) state_d = ST_ANC_RD;
			ST_ANC_RD:   state_d = (i_q == count_q) ? ST_PICK : ST_ANC_CHK;
			ST_ANC_CHK:  state_d = usable(rd_e) ? ST_MEM_RD : ST_ANC_RD;
			ST_MEM_RD:   state_d = (j_q == count_q) ? ST_ANC_END : ST_MEM_MUL;
			ST_MEM_MUL:  if (ph_q == 3'd3) state_d = ST_MEM_RD;
			ST_ANC_END:  state_d = ST_ANC_RD;
			ST_PICK:     state_d = majority ? ST_AVG_RD : ST_RESULT;
			ST_AVG_RD:   state_d = (i_q == count_q) ? ST_DIV_LOAD : ST_AVG_ACC;
			ST_AVG_ACC:  state_d = ST_AVG_RD;
			ST_DIV_LOAD: state_d = ST_DIV_STEP;
			ST_DIV_STEP: if (bit_q == BITCNT_W'(SUM_W - 1)) state_d = ST_DIV_DONE;
			ST_DIV_DONE: state_d = (axis_q == 2'd2) ? ST_RESULT : ST_DIV_LOAD;
			ST_RESULT:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, store port, squarer operand
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = i_q[IDX_W-1:0];
		mul_op    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = acc_in && (count_q < CNT_W'(MAX_REPORTS));
			end
			ST_OWN_MUL: begin
				case (ph_q)
					3'd0:    mul_op = rel_x_q;
					3'd1:    mul_op = rel_y_q;
					3'd2:    mul_op = rel_z_q;
					default: mul_op = self_radius_q;
				endcase
			end
			ST_GR2_MUL: mul_op = group_radius_q;
			ST_MEM_RD, ST_MEM_MUL: begin
				ram_raddr = j_q[IDX_W-1:0];
				case (ph_q)
					3'd0:    mul_op = mag17({rd_e.wx[POS_W-1], rd_e.wx}
						- {anc_q.wx[POS_W-1], anc_q.wx});
					3'd1:    mul_op = mag17({rd_e.wy[POS_W-1], rd_e.wy}
						- {anc_q.wy[POS_W-1], anc_q.wy});
					default: mul_op = mag17({rd_e.wz[POS_W-1], rd_e.wz}
						- {anc_q.wz[POS_W-1], anc_q.wz});
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			own_valid_q    <= 1'b0;
			own_near_q     <= 1'b0;
			m_tvalid_q     <= 1'b0;
			self_radius_q  <= 16'd500;
			group_radius_q <= 16'd1000;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SELF_RADIUS:  self_radius_q  <= cfg_data;
					CFG_GROUP_RADIUS: group_radius_q <= cfg_data;
					default: ;
				endcase
			end
			if (ram_we) begin
				count_q <= count_q + 1'b1;
				if (is_own_in) own_valid_q <= 1'b1;
			end
			if ((state_q == ST_OWN_MUL) && (ph_q == 3'd4)) begin
				own_near_q <= (own_q.status == 3'b111)
					&& ((own_q.kind[KD_CART] && (acc_q <= {2'b00, prod_q}))
					|| (own_q.kind[KD_POLAR] && (polar_q <= self_radius_q)));
			end
			if ((state_q == ST_RESULT) && out_free) begin
				m_tvalid_q  <= 1'b1;
				count_q     <= '0;
				own_valid_q <= 1'b0;
				own_near_q  <= 1'b0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ph_q   <= (state_d != state_q) ? 3'd0 : ph_q + 3'd1;
		prod_q <= mul_op * mul_op;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					last_q <= s_tlast;
					if (ram_we && is_own_in) begin
						own_q   <= ram_wdata;
						rel_x_q <= mag17({s_tdata[66], s_tdata[66:51]});
						rel_y_q <= mag17({s_tdata[82], s_tdata[82:67]});
						rel_z_q <= mag17({s_tdata[98], s_tdata[98:83]});
						polar_q <= s_tdata[114:99];
					end
				end
			end
			ST_OWN_MUL: begin
				if (ph_q == 3'd0) acc_q <= '0;
				else if (ph_q != 3'd4) acc_q <= acc_q + {2'b00, prod_q};
			end
			ST_START: begin
				src_q       <= SRC_OWN_NEAR;
				i_q         <= '0;
				best_q      <= '0;
				best_size_q <= '0;
				unamb_q     <= 1'b0;
			end
			ST_GR2_MUL: if (ph_q == 3'd1) gr2_q <= prod_q;
			ST_ANC_CHK: begin
				anc_q  <= rd_e;
				j_q    <= '0;
				mask_q <= '0;
				size_q <= '0;
				if (!usable(rd_e)) i_q <= i_q + 1'b1;
			end
			ST_MEM_MUL: begin
				if (ph_q == 3'd0) acc_q <= '0;
				else if (ph_q != 3'd3) acc_q <= acc_q + {2'b00, prod_q};
				else begin
					j_q <= j_q + 1'b1;
					if (in_group) begin
						mask_q[j_q[IDX_W-1:0]] <= 1'b1;
						size_q <= size_q + 1'b1;
					end
				end
			end
			ST_ANC_END: begin
				i_q <= i_q + 1'b1;
				if (size_q > best_size_q) begin
					best_q      <= mask_q;
					best_size_q <= size_q;
					unamb_q     <= 1'b1;
				end else if (size_q == best_size_q) begin
					unamb_q <= unamb_q && (mask_q == best_q);
				end
			end
			ST_PICK: begin
				i_q       <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				sum_z_q   <= '0;
				avg_cnt_q <= '0;
				axis_q    <= 2'd0;
				if (majority) src_q <= SRC_MAJORITY;
				else src_q <= own_valid_q ? SRC_OWN_COPY : SRC_NONE;
			end
			ST_AVG_ACC: begin
				i_q <= i_q + 1'b1;
				if (best_q[i_q[IDX_W-1:0]] && usable(rd_e)) begin
					sum_x_q   <= sum_x_q + SUM_W'($signed(rd_e.wx));
					sum_y_q   <= sum_y_q + SUM_W'($signed(rd_e.wy));
					sum_z_q   <= sum_z_q + SUM_W'($signed(rd_e.wz));
					avg_cnt_q <= avg_cnt_q + 1'b1;
				end
			end
			ST_DIV_LOAD: begin
				neg_q <= sum_sel[SUM_W-1];
				dvd_q <= sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
				rem_q <= '0;
				bit_q <= '0;
			end
			ST_DIV_STEP: begin
				bit_q <= bit_q + 1'b1;
				if (rem_sh >= {1'b0, avg_cnt_q}) begin
					rem_q <= CNT_W'(rem_sh - {1'b0, avg_cnt_q});
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[CNT_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
				end
			end
			ST_DIV_DONE: begin
				axis_q <= axis_q + 2'd1;
				unique case (axis_q)
					2'd0:    qx_q <= q_fix[POS_W-1:0];
					2'd1:    qy_q <= q_fix[POS_W-1:0];
					default: qz_q <= q_fix[POS_W-1:0];
				endcase
			end
			ST_RESULT: begin
				if (out_free) begin
					m_tuser_q <= src_q;
					unique case (src_q)
						SRC_OWN_NEAR, SRC_OWN_COPY: begin
							m_tdata_q <= own_q.kind[KD_WORLD]
								? {1'b0, 5'd0, own_q.status[ST_VISIBLE], 1'b1,
								   own_q.wz, own_q.wy, own_q.wx}
								: {1'b0, 5'd0, own_q.status[ST_VISIBLE], 1'b0, 48'd0};
						end
						SRC_MAJORITY: begin
							m_tdata_q <= (avg_cnt_q != '0)
								? {1'b0, 5'(best_size_q), 1'b1, 1'b1, qz_q, qy_q, qx_q}
								: {1'b0, 5'(best_size_q), 1'b1, 1'b0, 48'd0};
						end
						default: m_tdata_q <= '0;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// store fill never runs past its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REPORTS))
		else $error("report count beyond store depth");

	// a division only runs with a nonzero member count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_STEP) |-> (avg_cnt_q != '0))
		else $error("division by zero member count");

	// a majority result always names a nonempty group
	a_majority_members: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (m_tuser_q == SRC_MAJORITY)) |-> (m_tdata_q[54:50] != 5'd0))
		else $error("majority result without members");

	// the input stays blocked while the grouping products run
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEM_MUL) |=> !acc_in)
		else $error("request taken during grouping");

endmodule

### tb/sv/position_majority_fuser_checker.sv
// ----------------------------------------------------------------------------
// position_majority_fuser_checker
// watches the report, result and register channels, predicts each fused
// result from the accepted reports and compares it field by field
// ----------------------------------------------------------------------------
module position_majority_fuser_checker
	import pmf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [119:0]         s_tdata,
	input  logic [3:0]           s_tuser,
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [55:0]          m_tdata,
	input  logic [1:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   results_seen
);

	typedef struct packed {
		src_t        src;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        wp;
		logic        seen;
		logic [4:0]  members;
	} fused_t;

	entry_t      reports [MAX_REPORTS];
	int          loaded;
	bit          own_seen;
	int          own_at;
	bit          own_close;
	logic [15:0] self_radius;
	logic [15:0] grp_radius;
	fused_t      expected_fusions [$];

	assign pending = expected_fusions.size();

	function automatic longint sgn(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint dist2(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
		longint dx, dy, dz;
		dx = sgn(ax) - sgn(bx);
		dy = sgn(ay) - sgn(by);
		dz = sgn(az) - sgn(bz);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic bit is_usable(entry_t e);
		return e.status == 3'b111 && e.kind[KD_WORLD];
	endfunction

	// copy of the own report, used for the near and the no majority outcomes
	function automatic fused_t own_copy(src_t src);
		fused_t f;
		entry_t o;
		f = '0;
		o = reports[own_at];
		f.src = src;
		if (o.kind[KD_WORLD]) begin
			f.x  = o.wx;
			f.y  = o.wy;
			f.z  = o.wz;
			f.wp = 1'b1;
		end
		f.seen = o.status[ST_VISIBLE];
		return f;
	endfunction

	function automatic fused_t fuse_set();
		fused_t                 f;
		logic [MAX_REPORTS-1:0] grp, best;
		int                     sz, best_size, cnt;
		bit                     unique_best;
		longint                 gr2, sx, sy, sz3;
		f = '0;
		if (own_seen && own_close)
			return own_copy(SRC_OWN_NEAR);
		gr2 = longint'(grp_radius) * longint'(grp_radius);
		best = '0;
		best_size = 0;
		unique_best = 0;
		for (int i = 0; i < loaded; i++) begin
			if (!is_usable(reports[i]))
				continue;
			grp = '0;
			grp[i] = 1'b1;
			for (int j = 0; j < loaded; j++) begin
				if (j == i || !reports[j].kind[KD_WORLD])
					continue;
				if (dist2(reports[j].wx, reports[j].wy, reports[j].wz,
						reports[i].wx, reports[i].wy, reports[i].wz) <= gr2)
					grp[j] = 1'b1;
			end
			sz = $countones(grp);
			if (sz > best_size) begin
				best_size = sz;
				best = grp;
				unique_best = 1;
			end else if (sz == best_size) begin
				unique_best = unique_best && (grp == best);
			end
		end
		if (best_size > 0 && unique_best) begin
			sx = 0;
			sy = 0;
			sz3 = 0;
			cnt = 0;
			for (int i = 0; i < loaded; i++) begin
				if (!best[i] || !is_usable(reports[i]))
					continue;
				sx += sgn(reports[i].wx);
				sy += sgn(reports[i].wy);
				sz3 += sgn(reports[i].wz);
				cnt++;
			end
			f.src = SRC_MAJORITY;
			if (cnt > 0) begin
				// signed division truncates toward zero
				f.x  = 16'(sx / cnt);
				f.y  = 16'(sy / cnt);
				f.z  = 16'(sz3 / cnt);
				f.wp = 1'b1;
			end
			f.seen = 1'b1;
			f.members = 5'(best_size);
		end else if (own_seen) begin
			f = own_copy(SRC_OWN_COPY);
		end else begin
			f.src = SRC_NONE;
		end
		return f;
	endfunction

	task automatic clear_set();
		loaded = 0;
		own_seen = 0;
		own_at = 0;
		own_close = 0;
	endtask

	task automatic absorb_report();
		entry_t      e;
		longint      rx, ry, rz, r;
		logic [15:0] pr;
		if (loaded < MAX_REPORTS) begin
			e.status = s_tdata[2:0];
			e.kind   = s_tuser[3:1];
			e.wx     = s_tdata[18:3];
			e.wy     = s_tdata[34:19];
			e.wz     = s_tdata[50:35];
			reports[loaded] = e;
			if (s_tuser[0]) begin
				rx = sgn(s_tdata[66:51]);
				ry = sgn(s_tdata[82:67]);
				rz = sgn(s_tdata[98:83]);
				pr = s_tdata[114:99];
				r  = longint'(self_radius);
				own_seen = 1;
				own_at = loaded;
				// radius in force at load time decides nearness
				own_close = e.status == 3'b111 &&
					((e.kind[KD_CART] && rx * rx + ry * ry + rz * rz <= r * r) ||
					 (e.kind[KD_POLAR] && longint'(pr) <= r));
			end
			loaded++;
		end
		if (s_tlast) begin
			expected_fusions = {expected_fusions, fuse_set()};
			clear_set();
		end
	endtask

	task automatic check_result();
		fused_t want;
		if (expected_fusions.size() == 0) begin
			$error("result with no set pending: tdata %h tuser %h", m_tdata, m_tuser);
			fail_count++;
			return;
		end
		want = expected_fusions.pop_front();
		results_seen++;
		if (m_tuser != want.src) begin
			$error("result_source expected %0d got %0d", want.src, m_tuser);
			fail_count++;
		end
		if (m_tdata[15:0] != want.x) begin
			$error("fused_x expected %0d got %0d", $signed(want.x), $signed(m_tdata[15:0]));
			fail_count++;
		end
		if (m_tdata[31:16] != want.y) begin
			$error("fused_y expected %0d got %0d", $signed(want.y), $signed(m_tdata[31:16]));
			fail_count++;
		end
		if (m_tdata[47:32] != want.z) begin
			$error("fused_z expected %0d got %0d", $signed(want.z), $signed(m_tdata[47:32]));
			fail_count++;
		end
		if (m_tdata[48] != want.wp) begin
			$error("world_present expected %0d got %0d", want.wp, m_tdata[48]);
			fail_count++;
		end
		if (m_tdata[49] != want.seen) begin
			$error("seen expected %0d got %0d", want.seen, m_tdata[49]);
			fail_count++;
		end
		if (m_tdata[54:50] != want.members) begin
			$error("group_members expected %0d got %0d", want.members, m_tdata[54:50]);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			self_radius = 16'd500;
			grp_radius = 16'd1000;
			expected_fusions.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SELF_RADIUS)
					self_radius = cfg_data;
				else if (cfg_index == CFG_GROUP_RADIUS)
					grp_radius = cfg_data;
			end
			if (s_tvalid && s_tready)
				absorb_report();
			if (m_tvalid && m_tready)
				check_result();
		end
	end

endmodule

### tb/sv/position_majority_fuser_core_tb.sv
// ----------------------------------------------------------------------------
// position_majority_fuser_core_tb
// drives report sets into the fuser under changing radii and flow control,
// a checker beside the block predicts every fused result and counts errors
// ----------------------------------------------------------------------------
module position_majority_fuser_core_tb;
	import pmf_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// report_status, world_x, world_y, world_z, rel_x, rel_y, rel_z, polar_range
	logic [119:0]         s_tdata;
	// is_own, kind_bits
	logic [3:0]           s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	// fused_x, fused_y, fused_z, world_present, seen, group_members
	logic [55:0]          m_tdata;
	// result_source
	logic [1:0]           m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int requests_sent;
	int sets_sent;
	int cycles;

	// flow control knobs, percent of cycles
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int spread;

	position_majority_fuser_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	position_majority_fuser_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, generous against the slowest set times every stall
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	// one report request, held until the block takes it
	task automatic send_report(input bit own, input logic [2:0] status, input logic [2:0] kind,
			input logic [15:0] wx, input logic [15:0] wy, input logic [15:0] wz,
			input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] rz,
			input logic [15:0] pr, input bit is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {5'b0, pr, rz, ry, rx, wz, wy, wx, status};
		s_tuser = {kind, own};
		s_tlast = is_last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		requests_sent++;
		if (is_last)
			sets_sent++;
	endtask

	// register writes only with the block drained
	task automatic write_radii(input logic [15:0] self_r, input logic [15:0] grp_r);
		while (pending != 0)
			@(negedge clk);
		repeat (2000) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_SELF_RADIUS;
		cfg_data = self_r;
		@(negedge clk);
		cfg_index = CFG_GROUP_RADIUS;
		cfg_data = grp_r;
		@(negedge clk);
		cfg_we = 1'b0;
		spread = (grp_r > 16'd6000) ? 3000 : int'(grp_r) / 2 + 1;
	endtask

	// a set of reports, mostly clustered around one or two centers
	task automatic random_set(input int n);
		logic [15:0] cx [2];
		logic [15:0] cy [2];
		logic [15:0] cz [2];
		logic [2:0]  status;
		logic [2:0]  kind;
		logic [15:0] rx, ry, rz, pr;
		int          c, mode;
		bit          own;
		for (int k = 0; k < 2; k++) begin
			cx[k] = 16'($urandom);
			cy[k] = 16'($urandom);
			cz[k] = 16'($urandom);
		end
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(3) == 0) ? 1 : 0;
			status = ($urandom_range(4) != 0) ? 3'b111 : 3'($urandom);
			kind = ($urandom_range(4) != 0) ? (3'($urandom) | 3'b001) : 3'($urandom);
			own = $urandom_range(5) == 0;
			mode = $urandom_range(9);
			if (mode == 0) begin
				rx = 16'($urandom);
				ry = 16'($urandom);
				rz = 16'($urandom);
				pr = 16'($urandom);
			end else begin
				rx = 16'($urandom_range(800)) - 16'd400;
				ry = 16'($urandom_range(800)) - 16'd400;
				rz = 16'($urandom_range(800)) - 16'd400;
				pr = 16'($urandom_range(1200));
			end
			if ($urandom_range(9) == 0)
				send_report(own, status, kind, 16'($urandom), 16'($urandom), 16'($urandom),
					rx, ry, rz, pr, i == n - 1);
			else
				send_report(own, status, kind,
					cx[c] + 16'($urandom_range(2 * spread)) - 16'(spread),
					cy[c] + 16'($urandom_range(2 * spread)) - 16'(spread),
					cz[c] + 16'($urandom_range(2 * spread)) - 16'(spread),
					rx, ry, rz, pr, i == n - 1);
		end
	endtask

	// at least the asked number of requests under one setting of radii and flow control
	task automatic random_phase(input int requests, input int idle_pct, input int stall_pct);
		int target, n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = requests_sent + requests;
		while (requests_sent < target) begin
			// mostly small sets, now and then a large one that can run past the store size
			n = ($urandom_range(19) == 0) ? $urandom_range(MAX_REPORTS + 3, 10)
				: $urandom_range(6, 1);
			random_set(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SELF_RADIUS;
		cfg_data = '0;
		requests_sent = 0;
		sets_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		spread = 501;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset radii, own near by cartesian range
		send_report(1, 3'b111, 3'b011, 16'd100, 16'd200, 16'd300,
			16'd300, 16'hFEC0, 16'd100, 16'd9000, 1);
		// own near by polar range only, extreme world values
		send_report(1, 3'b111, 3'b101, 16'h8000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h8000, 16'h8000, 16'd500, 1);
		// own far, three close usable reports form a majority
		send_report(1, 3'b111, 3'b011, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
		send_report(0, 3'b111, 3'b001, 16'hFFF6, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b111, 3'b001, 16'hFFF5, 16'd8, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b111, 3'b111, 16'hFFF0, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1);
		// two disjoint pairs of the same size: no majority, no own report
		send_report(0, 3'b111, 3'b001, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b111, 3'b001, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b111, 3'b001, 16'd9000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b111, 3'b001, 16'd9010, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1);
		// own copied without world data, nothing usable
		send_report(1, 3'b011, 3'b110, 16'd77, 16'd77, 16'd77, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(0, 3'b101, 3'b001, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1);
		// two own reports, the later one stands
		send_report(1, 3'b111, 3'b011, 16'd5, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_report(1, 3'b110, 3'b001, 16'd9, 16'd9, 16'd9, 16'd0, 16'd0, 16'd0, 16'd0, 1);
		// store full: own mark and last on dropped reports
		for (int i = 0; i < MAX_REPORTS + 2; i++)
			send_report(i >= MAX_REPORTS, 3'b111, 3'b011, 16'(i * 3000), 16'd0, 16'd0,
				16'd0, 16'd0, 16'd0, 16'd0, i == MAX_REPORTS + 1);

		// long receiver hold-off while reports keep coming
		hold_left = HOLD_CYCLES;
		random_phase(60, 0, 0);

		write_radii(16'd0, 16'd0);
		random_phase(150, 0, 0);
		write_radii(16'hFFFF, 16'hFFFF);
		random_phase(150, 64, 0);
		write_radii(16'($urandom_range(2000)), 16'($urandom_range(3000)));
		random_phase(200, 0, 64);
		write_radii(16'd500, 16'd1000);
		random_phase(200, 11, 11);
		write_radii(16'($urandom), 16'($urandom_range(500)));
		random_phase(180, 64, 64);
		write_radii(16'd300, 16'd2500);
		random_phase(180, 0, 0);

		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		$display("run covered %0d report requests in %0d sets, %0d fused results checked",
			requests_sent, sets_sent, results_seen);
		$display("radii swept through zero, full scale and mid values under four stall mixes");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
